/* hdl/tlc_pkg.sv */
// Shared constants and types for the line ending and detab converter.
package tlc_pkg;

   localparam int MAX_TAB_WIDTH = 64;
   localparam int COL_W         = $clog2(MAX_TAB_WIDTH);
   localparam int CNT_W         = $clog2(MAX_TAB_WIDTH + 1);

   localparam logic [7:0] CHR_CR    = 8'd13;
   localparam logic [7:0] CHR_LF    = 8'd10;
   localparam logic [7:0] CHR_TAB   = 8'd9;
   localparam logic [7:0] CHR_SPACE = 8'd32;

   localparam logic [2:0] MODE_CR_TO_LF = 3'd0;
   localparam logic [2:0] MODE_LF_TO_CR = 3'd1;
   localparam logic [2:0] MODE_LF_PAIRS = 3'd2;
   localparam logic [2:0] MODE_CR_PAIRS = 3'd3;
   localparam logic [2:0] MODE_DETAB    = 3'd4;

   localparam logic REG_MODE      = 1'b0;
   localparam logic REG_TAB_WIDTH = 1'b1;

   typedef struct packed {
      logic [7:0]       first_byte;
      logic [7:0]       next_byte;
      logic [CNT_W-1:0] count;
      logic             stream_end;
   } cmd_type;

endpackage

/* hdl/tlc_front.sv */
// Front end: accepts input bytes, keeps conversion state, issues output commands.
module tlc_front (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    clear,
   input  logic                    tw_load,
   input  logic [2:0]              mode,
   input  logic [6:0]              tab_width,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic [7:0]              req_in_byte,
   input  logic                    req_in_last,
   input  logic                    q_full,
   output logic                    push,
   output tlc_pkg::cmd_type        push_cmd
);
   import tlc_pkg::*;

   logic             held_ff, held_in;
   logic             pjc_ff, pjc_in;
   logic [COL_W-1:0] col_ff, col_in;
   logic [COL_W-1:0] wcol_ff, wcol_in;
   logic [CNT_W-1:0] tw_eff;
   logic [CNT_W-1:0] col_ext;
   logic [CNT_W-1:0] col_inc;
   logic [CNT_W-1:0] col_red;
   logic [7:0]       brk;
   logic             reduce;
   logic             accept;

   always_comb begin
      if (tab_width == 7'd0) begin
         tw_eff = CNT_W'(1);
      end else if (tab_width > 7'(MAX_TAB_WIDTH)) begin
         tw_eff = CNT_W'(MAX_TAB_WIDTH);
      end else begin
         tw_eff = CNT_W'(tab_width);
      end
   end

   assign col_ext   = CNT_W'(wcol_ff);
   assign col_inc   = col_ext + CNT_W'(1);
   assign col_red   = col_ext - tw_eff;
   assign reduce    = (col_ext >= tw_eff);
   assign req_ready = !q_full && !reduce;
   assign accept    = req_valid && req_ready;
   assign brk       = (mode == MODE_LF_PAIRS) ? CHR_LF : CHR_CR;

   always_comb begin
      push                = 1'b0;
      push_cmd.first_byte = req_in_byte;
      push_cmd.next_byte  = req_in_byte;
      push_cmd.count      = CNT_W'(1);
      push_cmd.stream_end = req_in_last;
      held_in             = held_ff;
      pjc_in              = pjc_ff;
      col_in              = col_ff;
      wcol_in             = wcol_ff;
      if (accept) begin
         case (mode) inside
            MODE_CR_TO_LF: begin
               push = 1'b1;
               push_cmd.first_byte = (req_in_byte == CHR_CR) ? CHR_LF : req_in_byte;
            end
            MODE_LF_TO_CR: begin
               push = 1'b1;
               push_cmd.first_byte = (req_in_byte == CHR_LF) ? CHR_CR : req_in_byte;
            end
            MODE_LF_PAIRS, MODE_CR_PAIRS: begin
               if (held_ff) begin
                  held_in = 1'b0;
                  push = 1'b1;
                  push_cmd.first_byte = brk;
                  if (req_in_byte == brk) begin
                     pjc_in = 1'b1;
                  end else begin
                     push_cmd.count = CNT_W'(2);
                     pjc_in = 1'b0;
                  end
               end else if (req_in_byte == brk && !pjc_ff) begin
                  if (req_in_last) begin
                     push = 1'b1;
                  end else begin
                     held_in = 1'b1;
                  end
                  pjc_in = 1'b0;
               end else begin
                  push = 1'b1;
                  pjc_in = 1'b0;
               end
            end
            MODE_DETAB: begin
               push = 1'b1;
               if (req_in_byte == CHR_TAB) begin
                  push_cmd.first_byte = CHR_SPACE;
                  push_cmd.next_byte  = CHR_SPACE;
                  push_cmd.count      = tw_eff - col_ext;
                  col_in = '0;
               end else if (req_in_byte == CHR_LF || req_in_byte == CHR_CR) begin
                  col_in = '0;
               end else begin
                  col_in = (col_inc == tw_eff) ? '0 : col_inc[COL_W-1:0];
               end
            end
            default: begin
               push = 1'b1;
            end
         endcase
         if (req_in_last) begin
            held_in = 1'b0;
            pjc_in  = 1'b0;
            col_in  = '0;
         end
         wcol_in = col_in;
      end else if (reduce) begin
         wcol_in = col_red[COL_W-1:0];
      end
      if (tw_load) begin
         wcol_in = col_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || clear) begin
         held_ff <= 1'b0;
         pjc_ff  <= 1'b0;
         col_ff  <= '0;
         wcol_ff <= '0;
      end else begin
         held_ff <= held_in;
         pjc_ff  <= pjc_in;
         col_ff  <= col_in;
         wcol_ff <= wcol_in;
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      held_ff |-> (mode == MODE_LF_PAIRS || mode == MODE_CR_PAIRS))
      else $error("held break outside a collapse mode");

   assert property (@(posedge clock) disable iff (reset)
      (accept && req_in_last) |=> (!held_ff && !pjc_ff && col_ff == '0))
      else $error("state not cleared after last byte");

endmodule

/* hdl/tlc_queue.sv */
// Command queue between the front end and the output sequencer.
module tlc_queue #(
   parameter int DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  tlc_pkg::cmd_type push_cmd,
   output logic             full,
   input  logic             pop,
   output tlc_pkg::cmd_type pop_cmd,
   output logic             empty
);
   import tlc_pkg::*;

   localparam int PTR_W = $clog2(DEPTH);
   localparam int FILL_W = $clog2(DEPTH + 1);

   cmd_type             slot_ff [DEPTH];
   logic [PTR_W-1:0]    wr_ff, wr_in;
   logic [PTR_W-1:0]    rd_ff, rd_in;
   logic [FILL_W-1:0]   fill_ff, fill_in;

   assign full    = (fill_ff == FILL_W'(DEPTH));
   assign empty   = (fill_ff == '0);
   assign pop_cmd = slot_ff[rd_ff];

   always_comb begin
      wr_in   = wr_ff;
      rd_in   = rd_ff;
      fill_in = fill_ff;
      if (push) begin
         wr_in = (wr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_in = (rd_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         fill_in = fill_ff + FILL_W'(1);
      end else if (pop && !push) begin
         fill_in = fill_ff - FILL_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff   <= '0;
         rd_ff   <= '0;
         fill_ff <= '0;
      end else begin
         wr_ff   <= wr_in;
         rd_ff   <= rd_in;
         fill_ff <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ff] <= push_cmd;
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      push |-> !full)
      else $error("queue overflow");

   assert property (@(posedge clock) disable iff (reset)
      pop |-> !empty)
      else $error("queue underflow");

endmodule

/* hdl/tlc_back.sv */
// Output sequencer: expands each command into result transactions.
module tlc_back (
   input  logic             clock,
   input  logic             reset,
   input  logic             q_empty,
   input  tlc_pkg::cmd_type q_cmd,
   output logic             q_pop,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output logic [7:0]       rsp_out_byte,
   output logic             rsp_run_last,
   output logic             rsp_stream_end
);
   import tlc_pkg::*;

   logic    busy_ff, busy_in;
   cmd_type cmd_ff, cmd_in;
   logic    last_one;
   logic    done;

   assign last_one       = (cmd_ff.count == CNT_W'(1));
   assign done           = busy_ff && rsp_ready && last_one;
   assign q_pop          = !q_empty && (!busy_ff || done);
   assign rsp_valid      = busy_ff;
   assign rsp_out_byte   = cmd_ff.first_byte;
   assign rsp_run_last   = last_one;
   assign rsp_stream_end = last_one && cmd_ff.stream_end;

   always_comb begin
      busy_in = busy_ff;
      cmd_in  = cmd_ff;
      if (q_pop) begin
         busy_in = 1'b1;
         cmd_in  = q_cmd;
      end else if (busy_ff && rsp_ready) begin
         if (last_one) begin
            busy_in = 1'b0;
         end else begin
            cmd_in.first_byte = cmd_ff.next_byte;
            cmd_in.count      = cmd_ff.count - CNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff <= cmd_in;
   end

   assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> (cmd_ff.count != '0))
      else $error("active command with zero count");

endmodule

/* hdl/text_line_ending_and_detab_converter.sv */
// Top level: register file, front end, command queue and output sequencer.
//
//   channel  direction  handshake          payload
//   req      in         req_valid/ready    req_in_byte, req_in_last
//   rsp      out        rsp_valid/ready    rsp_out_byte, rsp_run_last, rsp_stream_end
//   csr      in         psel/penable       paddr, pwrite, pwdata, prdata, pready
//
// One input byte is taken per cycle while the queue has room and no column reduction is
// pending; a byte giving N results occupies the output sequencer until all N are taken.
// After a tab_width write that leaves the column at or beyond the new width, input stalls
// while the new width is subtracted from the column until the column is below it.
// Reset is synchronous; it clears state and sets mode 0, tab width 8.
// A stalled result holds in the sequencer while the queue keeps absorbing input.
module text_line_ending_and_detab_converter #(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_in_byte,
   input  logic        req_in_last,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_out_byte,
   output logic        rsp_run_last,
   output logic        rsp_stream_end,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);
   import tlc_pkg::*;

   logic [2:0] mode_ff, mode_in;
   logic [6:0] tab_width_ff, tab_width_in;
   logic       csr_write;
   logic       clear;
   logic       tw_load;
   logic       push, pop, q_full, q_empty;
   cmd_type    push_cmd, pop_cmd;

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;
   assign clear     = csr_write && (paddr[2] == REG_MODE);
   assign tw_load   = csr_write && (paddr[2] == REG_TAB_WIDTH);
   assign prdata    = (paddr[2] == REG_MODE) ? {29'd0, mode_ff} : {25'd0, tab_width_ff};

   always_comb begin
      mode_in      = mode_ff;
      tab_width_in = tab_width_ff;
      if (csr_write) begin
         if (paddr[2] == REG_MODE) begin
            mode_in = pwdata[2:0];
         end else begin
            tab_width_in = pwdata[6:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= MODE_CR_TO_LF;
         tab_width_ff <= 7'd8;
      end else begin
         mode_ff      <= mode_in;
         tab_width_ff <= tab_width_in;
      end
   end

   tlc_front u_front (
      .clock       (clock),
      .reset       (reset),
      .clear       (clear),
      .tw_load     (tw_load),
      .mode        (mode_ff),
      .tab_width   (tab_width_ff),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_in_byte (req_in_byte),
      .req_in_last (req_in_last),
      .q_full      (q_full),
      .push        (push),
      .push_cmd    (push_cmd)
   );

   tlc_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .full     (q_full),
      .pop      (pop),
      .pop_cmd  (pop_cmd),
      .empty    (q_empty)
   );

   tlc_back u_back (
      .clock          (clock),
      .reset          (reset),
      .q_empty        (q_empty),
      .q_cmd          (pop_cmd),
      .q_pop          (pop),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_out_byte   (rsp_out_byte),
      .rsp_run_last   (rsp_run_last),
      .rsp_stream_end (rsp_stream_end)
   );

endmodule
